// ----- src/fac_pkg.sv -----
`timescale 1ns / 1ps

package fac_pkg;

	localparam int PLANE_COUNT_DEF = 6;
	localparam int COORD_BITS_DEF  = 16;

	localparam int NUM_PLANES   = 6;
	localparam int PLANE_BITS   = 64;
	localparam int CFG_IDX_BITS = 3;
	localparam int NORM_BITS    = 16;
	localparam int Q_FRAC       = 14;
	localparam int VERDICT_BITS = 2;

	typedef enum logic [VERDICT_BITS-1:0] {
		VERDICT_INSIDE    = 2'd0,
		VERDICT_INTERSECT = 2'd1,
		VERDICT_OUTSIDE   = 2'd2
	} verdict_t;

	// Packed as written on the configuration port: nx in the low half-word.
	typedef struct packed {
		logic signed [NORM_BITS-1:0] d;
		logic signed [NORM_BITS-1:0] nz;
		logic signed [NORM_BITS-1:0] ny;
		logic signed [NORM_BITS-1:0] nx;
	} plane_t;

	typedef struct packed {
		logic adv_s2;
		logic adv_s3;
	} lane_ctl_t;

endpackage

// ----- src/fac_box_if.sv -----
`timescale 1ns / 1ps

interface fac_box_if #(
	parameter int COORD_BITS = 16
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] min_x;
	logic signed [COORD_BITS-1:0] min_y;
	logic signed [COORD_BITS-1:0] min_z;
	logic signed [COORD_BITS-1:0] max_x;
	logic signed [COORD_BITS-1:0] max_y;
	logic signed [COORD_BITS-1:0] max_z;
	logic signed [COORD_BITS-1:0] pos_x;
	logic signed [COORD_BITS-1:0] pos_y;
	logic signed [COORD_BITS-1:0] pos_z;

	modport source (
		output valid, min_x, min_y, min_z, max_x, max_y, max_z, pos_x, pos_y, pos_z,
		input  ready
	);
	modport sink (
		input  valid, min_x, min_y, min_z, max_x, max_y, max_z, pos_x, pos_y, pos_z,
		output ready
	);
endinterface

// ----- src/fac_verdict_if.sv -----
`timescale 1ns / 1ps

interface fac_verdict_if import fac_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [VERDICT_BITS-1:0] verdict;

	modport source (output valid, verdict, input ready);
	modport sink (input valid, verdict, output ready);
endinterface

// ----- src/fac_cfg_if.sv -----
`timescale 1ns / 1ps

interface fac_cfg_if import fac_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [CFG_IDX_BITS-1:0] index;
	logic [PLANE_BITS-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- src/fac_planes.sv -----
`timescale 1ns / 1ps

module fac_planes import fac_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	fac_cfg_if.sink    cfg,
	output plane_t     planes [NUM_PLANES]
);

	plane_t planes_q [NUM_PLANES];

	assign cfg.ready = 1'b1;

	// Drop writes beyond the last plane.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PLANES; i++) begin
				planes_q[i] <= '0;
			end
		end else if (cfg.valid && (cfg.index < CFG_IDX_BITS'(NUM_PLANES))) begin
			planes_q[cfg.index] <= plane_t'(cfg.data);
		end
	end

	assign planes = planes_q;

endmodule

// ----- src/fac_plane_lane.sv -----
`timescale 1ns / 1ps

module fac_plane_lane import fac_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                       clk,
	input  lane_ctl_t                  ctl,
	input  plane_t                     plane,
	input  logic signed [COORD_BITS:0] lo [3],
	input  logic signed [COORD_BITS:0] hi [3],
	output logic                       behind_p,
	output logic                       behind_n
);

	localparam int VB = COORD_BITS + 1;
	localparam int PW = NORM_BITS + VB;
	localparam int DW = NORM_BITS + Q_FRAC + 1;
	localparam int SW = ((PW > DW) ? PW : DW) + 2;

	logic signed [NORM_BITS-1:0] nrm [3];
	logic signed [VB-1:0]        pv [3];
	logic signed [VB-1:0]        nv [3];
	logic signed [PW-1:0]        pprod_s2 [3];
	logic signed [PW-1:0]        nprod_s2 [3];
	logic signed [SW-1:0]        psum;
	logic signed [SW-1:0]        nsum;
	logic signed [SW-1:0]        dterm;
	logic                        behind_p_s3;
	logic                        behind_n_s3;

	assign nrm[0] = plane.nx;
	assign nrm[1] = plane.ny;
	assign nrm[2] = plane.nz;

	// A clear sign bit picks the upper corner for the positive vertex.
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			pv[a] = nrm[a][NORM_BITS-1] ? lo[a] : hi[a];
			nv[a] = nrm[a][NORM_BITS-1] ? hi[a] : lo[a];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv_s2) begin
			for (int a = 0; a < 3; a++) begin
				pprod_s2[a] <= nrm[a] * pv[a];
				nprod_s2[a] <= nrm[a] * nv[a];
			end
		end
	end

	assign dterm = SW'(plane.d) <<< Q_FRAC;
	assign psum  = SW'(pprod_s2[0]) + SW'(pprod_s2[1]) + SW'(pprod_s2[2]) + dterm;
	assign nsum  = SW'(nprod_s2[0]) + SW'(nprod_s2[1]) + SW'(nprod_s2[2]) + dterm;

	always_ff @(posedge clk) begin
		if (ctl.adv_s3) begin
			behind_p_s3 <= psum[SW-1];
			behind_n_s3 <= nsum[SW-1];
		end
	end

	assign behind_p = behind_p_s3;
	assign behind_n = behind_n_s3;

endmodule

// ----- src/frustum_aabb_cull_top.sv -----
`timescale 1ns / 1ps

// Classifies one axis-aligned box per word against up to six frustum planes and returns
// inside, intersecting or outside. A new box is taken every clock cycle unless result
// backpressure has filled all stages. The box passes four register stages (vertex add,
// per-plane multiplies, per-plane sum and sign, verdict register), and the verdict is
// offered from the verdict register. Each stage holds under backpressure, so bubbles are
// squeezed out before the input stalls. Plane registers are written through the cfg
// channel, which is always ready; write planes only while no box is in flight.

module frustum_aabb_cull_top import fac_pkg::*; #(
	parameter int PLANE_COUNT = PLANE_COUNT_DEF,
	parameter int COORD_BITS  = COORD_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	fac_box_if.sink        box,
	fac_verdict_if.source  result,
	fac_cfg_if.sink        cfg
);

	localparam int VB = COORD_BITS + 1;

	plane_t                planes [NUM_PLANES];
	lane_ctl_t             lane_ctl;
	logic signed [VB-1:0]  lo_s1 [3];
	logic signed [VB-1:0]  hi_s1 [3];
	logic [PLANE_COUNT-1:0] behind_p;
	logic [PLANE_COUNT-1:0] behind_n;
	logic                  valid_s1_q;
	logic                  valid_s2_q;
	logic                  valid_s3_q;
	logic                  valid_s4_q;
	logic                  ready_s1;
	logic                  ready_s2;
	logic                  ready_s3;
	logic                  ready_s4;
	verdict_t              verdict_s4;
	verdict_t              verdict_d;

	fac_planes u_planes (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.planes (planes)
	);

	assign ready_s4 = !valid_s4_q || result.ready;
	assign ready_s3 = !valid_s3_q || ready_s4;
	assign ready_s2 = !valid_s2_q || ready_s3;
	assign ready_s1 = !valid_s1_q || ready_s2;
	assign box.ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_q <= 1'b0;
			valid_s2_q <= 1'b0;
			valid_s3_q <= 1'b0;
			valid_s4_q <= 1'b0;
		end else begin
			if (ready_s1) valid_s1_q <= box.valid;
			if (ready_s2) valid_s2_q <= valid_s1_q;
			if (ready_s3) valid_s3_q <= valid_s2_q;
			if (ready_s4) valid_s4_q <= valid_s3_q;
		end
	end

	// Absolute corners, one bit wider so the add never wraps.
	always_ff @(posedge clk) begin
		if (ready_s1) begin
			lo_s1[0] <= VB'(box.pos_x) + VB'(box.min_x);
			lo_s1[1] <= VB'(box.pos_y) + VB'(box.min_y);
			lo_s1[2] <= VB'(box.pos_z) + VB'(box.min_z);
			hi_s1[0] <= VB'(box.pos_x) + VB'(box.max_x);
			hi_s1[1] <= VB'(box.pos_y) + VB'(box.max_y);
			hi_s1[2] <= VB'(box.pos_z) + VB'(box.max_z);
		end
	end

	assign lane_ctl.adv_s2 = ready_s2;
	assign lane_ctl.adv_s3 = ready_s3;

	for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_lane
		fac_plane_lane #(
			.COORD_BITS (COORD_BITS)
		) u_lane (
			.clk      (clk),
			.ctl      (lane_ctl),
			.plane    (planes[p]),
			.lo       (lo_s1),
			.hi       (hi_s1),
			.behind_p (behind_p[p]),
			.behind_n (behind_n[p])
		);
	end

	// Any positive vertex behind a plane wins over every intersect.
	always_comb begin
		if (|behind_p) begin
			verdict_d = VERDICT_OUTSIDE;
		end else if (|behind_n) begin
			verdict_d = VERDICT_INTERSECT;
		end else begin
			verdict_d = VERDICT_INSIDE;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s4) begin
			verdict_s4 <= verdict_d;
		end
	end

	assign result.valid   = valid_s4_q;
	assign result.verdict = verdict_s4;

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!box.ready |-> (valid_s1_q && valid_s2_q && valid_s3_q && valid_s4_q))
		else $error("input stalled while the pipeline holds a bubble");

	a_result_from_stage3: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s4_q) |-> $past(valid_s3_q))
		else $error("result raised without a word in the sum stage");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s4_q && !result.ready) |=> (valid_s4_q && $stable(verdict_s4)))
		else $error("waiting verdict changed before it was taken");

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
	import fac_pkg::*;

	localparam int COORD_W     = COORD_BITS_DEF;
	localparam int IDLE_PCT    = 31;
	localparam int LONG_HOLD   = 80;
	localparam int SETTLE      = 6;
	localparam int QUIET_LIMIT = 2000;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		PL_RIGHT, PL_LEFT, PL_BOTTOM, PL_TOP, PL_BACK, PL_FRONT, PL_SPARE_A, PL_SPARE_B
	} plane_idx_t;

	typedef enum int {FR_CUBE, FR_JITTER, FR_EXTREME, FR_NOISE} frustum_style_t;

	// Axis 0..2 is x, y, z; corners are relative to pos.
	typedef struct packed {
		logic [2:0][COORD_W-1:0] lo;
		logic [2:0][COORD_W-1:0] hi;
		logic [2:0][COORD_W-1:0] pos;
	} box_t;

	logic clk;
	logic arst_n = 1'b0;

	logic                    box_valid = 1'b0;
	box_t                    box_word  = '0;
	logic                    box_took  = 1'b0;
	logic                    verdict_ready = 1'b0;
	logic                    cfg_valid = 1'b0;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [PLANE_BITS-1:0]   cfg_data  = '0;

	plane_t   planes [NUM_PLANES] = '{default: '0};
	box_t     pending_boxes [$];
	verdict_t verdicts_due [$];
	int       boxes_sent    = 0;
	int       verdicts_seen = 0;
	int       errors        = 0;
	int       quiet_cycles  = 0;
	bit       no_gaps       = 1'b0;
	int       hold_asked    = 0;
	int       hold_given    = 0;
	int       hold_left     = 0;

	fac_box_if #(.COORD_BITS(COORD_W)) box_ch ();
	fac_verdict_if res_ch ();
	fac_cfg_if cfg_ch ();

	assign box_ch.valid = box_valid;
	assign box_ch.min_x = box_word.lo[0];
	assign box_ch.min_y = box_word.lo[1];
	assign box_ch.min_z = box_word.lo[2];
	assign box_ch.max_x = box_word.hi[0];
	assign box_ch.max_y = box_word.hi[1];
	assign box_ch.max_z = box_word.hi[2];
	assign box_ch.pos_x = box_word.pos[0];
	assign box_ch.pos_y = box_word.pos[1];
	assign box_ch.pos_z = box_word.pos[2];
	assign res_ch.ready = verdict_ready;
	assign cfg_ch.valid = cfg_valid;
	assign cfg_ch.index = cfg_index;
	assign cfg_ch.data  = cfg_data;

	frustum_aabb_cull_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.box    (box_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic bit behind_plane(longint n[3], longint d, longint v[3]);
		return n[0] * v[0] + n[1] * v[1] + n[2] * v[2] + (d <<< Q_FRAC) < 0;
	endfunction

	function automatic verdict_t classify_box(box_t b);
		longint lo[3], hi[3], pos[3], n[3], pv[3], nv[3];
		longint d;
		verdict_t v;
		v = VERDICT_INSIDE;
		for (int a = 0; a < 3; a++) begin
			lo[a]  = longint'($signed(b.lo[a]));
			hi[a]  = longint'($signed(b.hi[a]));
			pos[a] = longint'($signed(b.pos[a]));
		end
		for (int p = 0; p < PLANE_COUNT_DEF; p++) begin
			n[0] = longint'($signed(planes[p].nx));
			n[1] = longint'($signed(planes[p].ny));
			n[2] = longint'($signed(planes[p].nz));
			d    = longint'($signed(planes[p].d));
			// zero counts as non-negative: upper corner is the positive vertex
			for (int a = 0; a < 3; a++) begin
				if (n[a] >= 0) begin
					pv[a] = pos[a] + hi[a];
					nv[a] = pos[a] + lo[a];
				end else begin
					pv[a] = pos[a] + lo[a];
					nv[a] = pos[a] + hi[a];
				end
			end
			if (behind_plane(n, d, pv))
				return VERDICT_OUTSIDE;
			if (behind_plane(n, d, nv))
				v = VERDICT_INTERSECT;
		end
		return v;
	endfunction

	function automatic logic [COORD_W-1:0] span(int r);
		return COORD_W'(int'($urandom_range(2 * r)) - r);
	endfunction

	function automatic logic [COORD_W-1:0] pick_extreme();
		case ($urandom_range(3))
			0: return COORD_W'(-32768);
			1: return COORD_W'(32767);
			2: return '0;
			default: return '1;
		endcase
	endfunction

	function automatic box_t mk(int lx, int ly, int lz, int hx, int hy, int hz,
			int px, int py, int pz);
		box_t b;
		b.lo  = {COORD_W'(lz), COORD_W'(ly), COORD_W'(lx)};
		b.hi  = {COORD_W'(hz), COORD_W'(hy), COORD_W'(hx)};
		b.pos = {COORD_W'(pz), COORD_W'(py), COORD_W'(px)};
		return b;
	endfunction

	function automatic box_t random_box();
		box_t b;
		int roll;
		bit point;
		roll  = $urandom_range(99);
		point = ($urandom_range(9) == 0);
		for (int a = 0; a < 3; a++) begin
			if (roll < 70) begin
				b.pos[a] = span(12000);
				b.lo[a]  = point ? '0 : COORD_W'(-int'($urandom_range(4000)));
				b.hi[a]  = point ? '0 : COORD_W'($urandom_range(4000));
			end else if (roll < 80) begin
				// lower corner above upper corner
				b.pos[a] = span(12000);
				b.lo[a]  = COORD_W'($urandom_range(4000));
				b.hi[a]  = COORD_W'(-int'($urandom_range(4000)));
			end else if (roll < 95) begin
				b.pos[a] = COORD_W'($urandom);
				b.lo[a]  = COORD_W'($urandom);
				b.hi[a]  = COORD_W'($urandom);
			end else begin
				b.pos[a] = pick_extreme();
				b.lo[a]  = pick_extreme();
				b.hi[a]  = pick_extreme();
			end
		end
		return b;
	endfunction

	function automatic plane_t frustum_plane(frustum_style_t style, int p, int reach);
		plane_t pl;
		int sense, mag;
		sense = (p == 0 || p == 3 || p == 4) ? -1 : 1;
		case (style)
			FR_CUBE: begin
				pl   = '0;
				mag  = 16384;
				pl.d = NORM_BITS'(reach);
			end
			FR_JITTER: begin
				pl.nx = span(3000);
				pl.ny = span(3000);
				pl.nz = span(3000);
				mag   = 12000 + int'($urandom_range(4383));
				pl.d  = NORM_BITS'(reach - 4000 + int'($urandom_range(8000)));
			end
			FR_EXTREME: begin
				pl.nx = pick_extreme();
				pl.ny = pick_extreme();
				pl.nz = pick_extreme();
				pl.d  = pick_extreme();
				return pl;
			end
			default: return plane_t'({$urandom, $urandom});
		endcase
		case (p / 2)
			0: pl.nx = NORM_BITS'(sense * mag);
			1: pl.ny = NORM_BITS'(sense * mag);
			default: pl.nz = NORM_BITS'(sense * mag);
		endcase
		return pl;
	endfunction

	// Leaves valid high; the caller drops it after the last write of a batch.
	task automatic cfg_write(plane_idx_t idx, plane_t val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		if (idx < NUM_PLANES)
			planes[idx] = val;
	endtask

	task automatic load_frustum(frustum_style_t style, int reach, bit spare);
		for (int p = 0; p < NUM_PLANES; p++)
			cfg_write(plane_idx_t'(p), frustum_plane(style, p, reach));
		if (spare) begin
			cfg_write(PL_SPARE_A, plane_t'({$urandom, $urandom}));
			cfg_write(PL_SPARE_B, plane_t'({$urandom, $urandom}));
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic offer(box_t b);
		pending_boxes.push_back(b);
		boxes_sent++;
	endtask

	task automatic wait_drain();
		do @(posedge clk); while (pending_boxes.size() != 0 || verdicts_seen < boxes_sent);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic run_phase(int count, bit with_hold, bit steady);
		@(posedge clk);
		no_gaps = steady;
		for (int i = 0; i < count; i++)
			offer(random_box());
		if (with_hold)
			hold_asked++;
		wait_drain();
		no_gaps = 1'b0;
	endtask

	// Hold the word until taken, then offer the next one or idle.
	always @(negedge clk) begin : box_driver
		if (arst_n && !(box_valid && !box_took)) begin
			if (pending_boxes.size() != 0 && (no_gaps || $urandom_range(99) >= IDLE_PCT)) begin
				box_word  <= pending_boxes.pop_front();
				box_valid <= 1'b1;
			end else
				box_valid <= 1'b0;
		end
	end

	always @(negedge clk) begin : verdict_sink
		if (hold_left != 0) begin
			hold_left     <= hold_left - 1;
			verdict_ready <= 1'b0;
		end else if (hold_asked != hold_given) begin
			hold_given    <= hold_given + 1;
			hold_left     <= LONG_HOLD;
			verdict_ready <= 1'b0;
		end else
			verdict_ready <= arst_n && (no_gaps || $urandom_range(99) >= IDLE_PCT);
	end

	always @(posedge clk) begin : verdict_check
		verdict_t want;
		box_took <= box_valid && box_ch.ready;
		if (arst_n) begin
			if (box_valid && box_ch.ready)
				verdicts_due.push_back(classify_box(box_word));
			if (res_ch.valid && verdict_ready) begin
				verdicts_seen <= verdicts_seen + 1;
				if (verdicts_due.size() == 0) begin
					$display("%0t: verdict %0d arrived with none expected", $time, res_ch.verdict);
					errors++;
				end else begin
					want = verdicts_due.pop_front();
					if (res_ch.verdict !== want) begin
						$display("%0t: verdict expected %0d got %0d", $time, want, res_ch.verdict);
						errors++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if (!arst_n || (box_valid && box_ch.ready) || (res_ch.valid && verdict_ready)
				|| (cfg_valid && cfg_ch.ready))
			quiet_cycles <= 0;
		else if (quiet_cycles == QUIET_LIMIT) begin
			$display("FAIL frustum_aabb_cull_top");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin : stimulus
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// planes still at reset: everything is inside
		offer(mk(-32768, -32768, -32768, 32767, 32767, 32767, -32768, -32768, -32768));
		offer(mk(-32768, -32768, -32768, 32767, 32767, 32767, 32767, 32767, 32767));
		offer(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
		wait_drain();

		load_frustum(FR_CUBE, 8000, 1'b0);
		@(posedge clk);
		offer(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
		offer(mk(0, 0, 0, 0, 0, 0, 9000, 0, 0));
		offer(mk(0, 0, 0, 0, 0, 0, -8000, 0, 0));
		offer(mk(0, 0, 0, 0, 0, 0, 0, -8001, 0));
		offer(mk(0, 0, 0, 0, 0, 0, 0, 0, 8000));
		offer(mk(-1000, -1000, -1000, 1000, 1000, 1000, 0, 0, 0));
		offer(mk(-1000, -1000, -1000, 1000, 1000, 1000, 7500, 0, 0));
		offer(mk(-1000, -1000, -1000, 1000, 1000, 1000, 0, 0, -7500));
		offer(mk(1000, 1000, 1000, -1000, -1000, -1000, 0, 0, 0));
		offer(mk(1000, 1000, 1000, -1000, -1000, -1000, 7500, 0, 0));
		offer(mk(-32768, -32768, -32768, 32767, 32767, 32767, 0, 0, 0));
		offer(mk(-32768, 0, -32768, 32767, 0, 32767, -32768, 0, 32767));
		offer(mk(0, 0, 0, 32767, 32767, 32767, 32767, 32767, 32767));
		wait_drain();

		load_frustum(FR_CUBE, 6000, 1'b0);
		run_phase(300, 1'b1, 1'b0);
		load_frustum(FR_JITTER, 8000, 1'b1);
		run_phase(400, 1'b0, 1'b0);
		load_frustum(FR_EXTREME, 0, 1'b0);
		run_phase(150, 1'b1, 1'b0);
		load_frustum(FR_NOISE, 0, 1'b1);
		run_phase(150, 1'b0, 1'b0);
		load_frustum(FR_JITTER, 10000, 1'b0);
		run_phase(350, 1'b0, 1'b1);

		if (errors == 0 && verdicts_due.size() == 0)
			$display("PASS frustum_aabb_cull_top");
		else
			$display("FAIL frustum_aabb_cull_top");
		$finish;
	end

endmodule
